@@ design/clbs_pkg.sv @@
// ----------------------------------------------------------------------------
// clbs_pkg: shared types and constants of the character LCD bus sequencer
// Op codes, modes, command bytes, state and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package clbs_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = 6;

  localparam logic [7:0] INIT_WAIT_TICKS = 8'd15;
  localparam logic [7:0] WAIT_MAX        = 8'hFF;
  localparam logic [CNT_W-1:0] BUF_DEPTH_CNT = CNT_W'(BUF_DEPTH);

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_CLR  = 2'd2;
  localparam logic [1:0] OP_POS  = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_POS   = 2'd3;

  localparam logic [1:0] STAGE_FUNC = 2'd0;
  localparam logic [1:0] STAGE_DISP = 2'd1;
  localparam logic [1:0] STAGE_CLR  = 2'd2;

  localparam logic [7:0] CMD_FUNC_SET  = 8'h30;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [7:0] ROW_TWO_OFS   = 8'h40;

  localparam logic [2:0] CFG_FONT_LARGE = 3'd0;
  localparam logic [2:0] CFG_TWO_LINES  = 3'd1;
  localparam logic [2:0] CFG_DISPLAY_ON = 3'd2;
  localparam logic [2:0] CFG_CURSOR_ON  = 3'd3;
  localparam logic [2:0] CFG_BLINK_ON   = 3'd4;

  typedef struct packed {
    logic font_large;
    logic two_lines;
    logic display_on;
    logic cursor_on;
    logic blink_on;
  } cfg_t;

  typedef struct packed {
    logic             init_done;
    logic [1:0]       init_stage;
    logic [7:0]       wait_count;
    logic [1:0]       active_mode;
    logic             enable_level;
    logic             select_level;
    logic [7:0]       data_level;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] send_index;
    logic [CNT_W-1:0] message_length;
    logic [5:0]       cursor_column;
    logic             cursor_row;
  } state_t;

  typedef struct packed {
    logic       accepted;
    logic       reg_select;
    logic [7:0] data_pins;
    logic       enable_pin;
    logic       write_done;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

endpackage

`default_nettype wire

@@ design/char_lcd_bus_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer: 8-bit parallel bus driver for a character LCD
// Each request either advances the bus by one tick or posts a request
// (message character, clear, cursor position); one result per request.
//
// Usage:
//   in_*  : request channel, valid/ready. op 0 is a bus tick, op 1 appends a
//           message character (last_char starts the write), op 2 clears, op 3
//           sets the cursor. Ops 1-3 are accepted only when idle after init.
//   out_* : one result per request: accepted flag, RS/RW/D0-D7/EN levels after
//           the request, a write_done pulse and the busy flag.
//   cfg_* : register writes (font, lines, display, cursor, blink), always ready.
// The result of a request is registered and valid the cycle after it is taken.
// One request per cycle barring a stall; the whole update is one pass of
// next-state logic plus one registered read of the 32-entry character buffer.
// Reset clears the control state and the result valid flag; the buffer holds
// garbage until written. When the receiver stalls, the held result blocks a
// new request only while out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_bus_sequencer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_char_value,
  input  wire logic       in_last_char,
  input  wire logic       in_row,
  input  wire logic [5:0] in_column,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_accepted,
  output logic            out_reg_select,
  output logic            out_read_write,
  output logic [7:0]      out_data_pins,
  output logic            out_enable_pin,
  output logic            out_write_done,
  output logic            out_busy_res,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic       cfg_data
);
  import clbs_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  cfg_t             cfg_r;
  result_t          res_nxt;
  result_t          res_r;
  buf_wr_t          buf_wr;
  logic             out_valid_r;
  logic             in_fire;
  logic [IDX_W-1:0] buf_rd_addr;
  logic [7:0]       buf_rd_r;
  logic [7:0]       buf_mem_r [BUF_DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign buf_rd_addr = state_nxt.send_index[IDX_W-1:0];

  clbs_step u_step (
    .cur         (state_r),
    .cfg         (cfg_r),
    .op          (in_op),
    .char_value  (in_char_value),
    .last_char   (in_last_char),
    .row         (in_row),
    .column      (in_column),
    .buf_rd_data (buf_rd_r),
    .nxt         (state_nxt),
    .res         (res_nxt),
    .buf_wr      (buf_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && buf_wr.we) begin
      buf_mem_r[buf_wr.addr] <= buf_wr.data;
    end
    if (in_fire) begin
      if (buf_wr.we && (buf_wr.addr == buf_rd_addr)) begin
        buf_rd_r <= buf_wr.data;
      end else begin
        buf_rd_r <= buf_mem_r[buf_rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_large <= 1'b0;
      cfg_r.two_lines  <= 1'b1;
      cfg_r.display_on <= 1'b1;
      cfg_r.cursor_on  <= 1'b0;
      cfg_r.blink_on   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FONT_LARGE: cfg_r.font_large <= cfg_data;
        CFG_TWO_LINES:  cfg_r.two_lines  <= cfg_data;
        CFG_DISPLAY_ON: cfg_r.display_on <= cfg_data;
        CFG_CURSOR_ON:  cfg_r.cursor_on  <= cfg_data;
        CFG_BLINK_ON:   cfg_r.blink_on   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = res_r.accepted;
  assign out_reg_select = res_r.reg_select;
  assign out_read_write = 1'b0;
  assign out_data_pins  = res_r.data_pins;
  assign out_enable_pin = res_r.enable_pin;
  assign out_write_done = res_r.write_done;
  assign out_busy_res   = res_r.busy_res;

`ifndef NO_ASSERTIONS
  a_done_en_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.write_done) |-> !res_r.enable_pin)
    else $error("write_done with EN high");

  a_idle_en_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.busy_res) |-> !res_r.enable_pin)
    else $error("EN high while idle");

  a_init_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.init_done |-> (state_r.active_mode == MODE_IDLE))
    else $error("request active before init");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.message_length <= BUF_DEPTH_CNT) && (state_r.fill_count <= BUF_DEPTH_CNT))
    else $error("buffer count beyond depth");
`endif

endmodule

`default_nettype wire

@@ design/clbs_step.sv @@
// ----------------------------------------------------------------------------
// clbs_step: next-state logic of the character LCD bus sequencer
// Applies one request to the current state and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module clbs_step (
  input  wire clbs_pkg::state_t  cur,
  input  wire clbs_pkg::cfg_t    cfg,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        char_value,
  input  wire logic              last_char,
  input  wire logic              row,
  input  wire logic [5:0]        column,
  input  wire logic [7:0]        buf_rd_data,
  output clbs_pkg::state_t       nxt,
  output clbs_pkg::result_t      res,
  output clbs_pkg::buf_wr_t      buf_wr
);
  import clbs_pkg::*;

  logic             idle_ready;
  logic [7:0]       wait_inc;
  logic [7:0]       init_cmd;
  logic [7:0]       pos_cmd;
  logic [7:0]       send_byte;
  logic [CNT_W-1:0] fill_inc;
  logic             acc;
  logic             done;

  always_comb begin
    case (cur.init_stage)
      STAGE_FUNC: init_cmd = CMD_FUNC_SET | {4'b0, cfg.two_lines, cfg.font_large, 2'b0};
      STAGE_DISP: init_cmd = CMD_DISP_CTRL
                             | {5'b0, cfg.display_on, cfg.cursor_on, cfg.blink_on};
      default:    init_cmd = CMD_CLEAR;
    endcase
  end

  assign pos_cmd    = CMD_SET_ADDR + {2'b0, cur.cursor_column}
                      + (cur.cursor_row ? ROW_TWO_OFS : 8'h00);
  assign send_byte  = (cur.send_index < BUF_DEPTH_CNT) ? buf_rd_data : 8'h00;
  assign idle_ready = cur.init_done && (cur.active_mode == MODE_IDLE);
  assign wait_inc   = (cur.wait_count != WAIT_MAX) ? cur.wait_count + 8'd1 : cur.wait_count;
  assign fill_inc   = cur.fill_count + CNT_W'(1);

  always_comb begin
    nxt         = cur;
    acc         = 1'b0;
    done        = 1'b0;
    buf_wr.we   = 1'b0;
    buf_wr.addr = cur.fill_count[IDX_W-1:0];
    buf_wr.data = char_value;
    case (op)
      OP_TICK: begin
        acc = 1'b1;
        if (!cur.init_done) begin
          nxt.wait_count = wait_inc;
          if (wait_inc >= INIT_WAIT_TICKS) begin
            if (cur.enable_level) begin
              nxt.enable_level = 1'b0;
              if (cur.init_stage >= STAGE_CLR) begin
                nxt.init_done = 1'b1;
              end else begin
                nxt.init_stage = cur.init_stage + 2'd1;
              end
            end else begin
              nxt.select_level = 1'b0;
              nxt.data_level   = init_cmd;
              nxt.enable_level = 1'b1;
            end
          end
        end else begin
          case (cur.active_mode)
            MODE_WRITE: begin
              if (cur.enable_level) begin
                nxt.enable_level = 1'b0;
              end else if (cur.send_index >= cur.message_length) begin
                nxt.active_mode = MODE_IDLE;
                nxt.send_index  = '0;
                done            = 1'b1;
              end else begin
                nxt.select_level = 1'b1;
                nxt.data_level   = send_byte;
                nxt.enable_level = 1'b1;
                nxt.send_index   = cur.send_index + CNT_W'(1);
              end
            end
            MODE_CLEAR, MODE_POS: begin
              if (cur.enable_level) begin
                nxt.enable_level = 1'b0;
                nxt.active_mode  = MODE_IDLE;
              end else begin
                nxt.select_level = 1'b0;
                nxt.data_level   = (cur.active_mode == MODE_CLEAR) ? CMD_CLEAR : pos_cmd;
                nxt.enable_level = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_CHAR: begin
        if (idle_ready) begin
          if (cur.fill_count < BUF_DEPTH_CNT) begin
            buf_wr.we      = 1'b1;
            nxt.fill_count = fill_inc;
            acc            = 1'b1;
          end
          if (last_char) begin
            nxt.message_length = nxt.fill_count;
            nxt.fill_count     = '0;
            nxt.send_index     = '0;
            nxt.active_mode    = MODE_WRITE;
            acc                = 1'b1;
          end
        end
      end
      OP_CLR: begin
        if (idle_ready) begin
          nxt.active_mode = MODE_CLEAR;
          acc             = 1'b1;
        end
      end
      OP_POS: begin
        if (idle_ready) begin
          nxt.cursor_row    = row;
          nxt.cursor_column = column;
          nxt.active_mode   = MODE_POS;
          acc               = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.accepted   = acc;
  assign res.reg_select = nxt.select_level;
  assign res.data_pins  = nxt.data_level;
  assign res.enable_pin = nxt.enable_level;
  assign res.write_done = done;
  assign res.busy_res   = !nxt.init_done || (nxt.active_mode != MODE_IDLE);

endmodule

`default_nettype wire
